// ===== hw/rtl/hcm_pkg.sv =====
// hcm_pkg: shared types, codes and lookup tables for the hall six-step commutator.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcm_pkg;

    // default sizing
    localparam int RING_DEPTH_DEF  = 6;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int DUTY_W     = 12;
    localparam int PHASE_BITS = 2;
    localparam int STEP_W     = 3;
    localparam int CODE_W     = 3;
    localparam int MODE_W     = 3;
    localparam int CAP_W      = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_STOP    = 2'd1;
    localparam logic [1:0] REQ_FAULT   = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_DUTY  = 1'd1;

    localparam logic [DUTY_W-1:0] RUN_DUTY_RST = 12'd50;

    // phase codes
    localparam logic [PHASE_BITS-1:0] PHASE_NONE = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_U    = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_V    = 2'd2;
    localparam logic [PHASE_BITS-1:0] PHASE_W    = 2'd3;

    // step that turns every switch off
    localparam logic [STEP_W-1:0] STEP_OFF = 3'd6;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 3'd0,
        MODE_START = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_ERROR = 3'd4
    } t_mode;

    typedef struct packed {
        logic [1:0] req_type;
        logic       hall_a;
        logic       hall_b;
        logic       hall_c;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_BITS-1:0] high_phase;
        logic [PHASE_BITS-1:0] low_phase;
        logic [DUTY_W-1:0]     duty_out;
        logic [MODE_W-1:0]     mode_out;
        logic                  stall_flag;
        logic                  capture_valid;
        logic [CAP_W-1:0]      capture_value;
        logic [SLOT_OUT_W-1:0] capture_slot;
    } t_out_item;

    typedef struct packed {
        logic              direction_forward;
        logic [DUTY_W-1:0] run_duty;
    } t_cfg;

    // hall code -> step, clockwise and counter-clockwise
    function automatic logic [STEP_W-1:0] step_lookup(input logic fwd,
                                                      input logic [CODE_W-1:0] code);
        logic [STEP_W-1:0] s;
        if (fwd) begin
            unique case (code)
                3'd0:    s = 3'd6;
                3'd1:    s = 3'd1;
                3'd2:    s = 3'd3;
                3'd3:    s = 3'd2;
                3'd4:    s = 3'd5;
                3'd5:    s = 3'd0;
                3'd6:    s = 3'd4;
                default: s = 3'd6;
            endcase
        end else begin
            unique case (code)
                3'd0:    s = 3'd6;
                3'd1:    s = 3'd4;
                3'd2:    s = 3'd0;
                3'd3:    s = 3'd5;
                3'd4:    s = 3'd2;
                3'd5:    s = 3'd3;
                3'd6:    s = 3'd1;
                default: s = 3'd6;
            endcase
        end
        return s;
    endfunction

    // step -> {high phase, low phase}; off step and unused codes give none/none
    function automatic logic [2*PHASE_BITS-1:0] step_pair(input logic [STEP_W-1:0] step);
        logic [2*PHASE_BITS-1:0] p;
        unique case (step)
            3'd0:    p = {PHASE_U, PHASE_V};
            3'd1:    p = {PHASE_U, PHASE_W};
            3'd2:    p = {PHASE_V, PHASE_W};
            3'd3:    p = {PHASE_V, PHASE_U};
            3'd4:    p = {PHASE_W, PHASE_U};
            3'd5:    p = {PHASE_W, PHASE_V};
            default: p = {PHASE_NONE, PHASE_NONE};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hcm_core.sv =====
// hcm_core: commutation state (mode, gates, duty, hall history, period timer, ring slot)
// and the single-pass next-state logic for one item. Uses hcm_pkg.
`default_nettype none

module hcm_core
    import hcm_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_result
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    t_mode                  r_mode,   n_mode;
    logic [CODE_W-1:0]      r_last,   n_last;
    logic [STEP_W-1:0]      r_step,   n_step;
    logic [DUTY_W-1:0]      r_duty,   n_duty;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic                   r_timer,  n_timer;
    logic [SLOT_W-1:0]      r_slot,   n_slot;
    logic [PHASE_BITS-1:0]  r_gate_h, n_gate_h;
    logic [PHASE_BITS-1:0]  r_gate_l, n_gate_l;

    logic [CODE_W-1:0]      code;
    logic                   cap;
    logic                   stall;
    t_mode                  req_mode;

    assign code = {i_item.hall_b, i_item.hall_c, i_item.hall_a};

    always_comb begin
        n_mode   = r_mode;
        n_last   = r_last;
        n_step   = r_step;
        n_duty   = r_duty;
        n_timer  = r_timer;
        n_slot   = r_slot;
        n_gate_h = r_gate_h;
        n_gate_l = r_gate_l;
        cap      = 1'b0;
        stall    = 1'b0;

        unique case (i_item.req_type)
            REQ_STOP:    req_mode = MODE_STOP;
            REQ_FAULT:   req_mode = MODE_ERROR;
            REQ_RESTART: req_mode = MODE_INIT;
            default:     req_mode = r_mode;
        endcase

        unique case (req_mode)
            MODE_INIT: begin
                n_gate_h = PHASE_NONE;
                n_gate_l = PHASE_NONE;
                n_duty   = '0;
                n_mode   = MODE_START;
            end
            MODE_START: begin
                n_last  = code;
                n_step  = step_lookup(i_cfg.direction_forward, code);
                {n_gate_h, n_gate_l} = step_pair(n_step);
                n_duty  = (n_step < STEP_OFF) ? i_cfg.run_duty : '0;
                n_mode  = MODE_RUN;
                n_timer = 1'b1;
            end
            MODE_RUN: begin
                n_duty = i_cfg.run_duty;
                n_mode = MODE_RUN;
            end
            MODE_STOP: begin
                n_gate_h = PHASE_NONE;
                n_gate_l = PHASE_NONE;
                n_duty   = '0;
                n_timer  = 1'b0;
                n_mode   = MODE_STOP;
            end
            MODE_ERROR: begin
                n_gate_h = PHASE_NONE;
                n_gate_l = PHASE_NONE;
                n_duty   = '0;
                n_mode   = MODE_ERROR;
            end
            default: n_mode = req_mode;
        endcase

        // hall edge check against the code as left by the mode action
        if (code != n_last) begin
            cap    = 1'b1;
            n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            n_last = code;
            if (n_mode == MODE_RUN) begin
                n_step = step_lookup(i_cfg.direction_forward, code);
                {n_gate_h, n_gate_l} = step_pair(n_step);
                n_duty = (n_step < STEP_OFF) ? i_cfg.run_duty : '0;
            end
        end else begin
            stall = (n_mode == MODE_RUN);
        end

        n_count = cap ? '0 : r_count;
        if (n_timer) begin
            n_count = n_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_INIT;
            r_last   <= '0;
            r_step   <= '0;
            r_duty   <= '0;
            r_count  <= '0;
            r_timer  <= 1'b0;
            r_slot   <= '0;
            r_gate_h <= PHASE_NONE;
            r_gate_l <= PHASE_NONE;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_last   <= n_last;
            r_step   <= n_step;
            r_duty   <= n_duty;
            r_count  <= n_count;
            r_timer  <= n_timer;
            r_slot   <= n_slot;
            r_gate_h <= n_gate_h;
            r_gate_l <= n_gate_l;
        end
    end

    // the ring entry itself is the captured value; the slot tells where it lands
    always_comb begin
        o_result.high_phase    = n_gate_h;
        o_result.low_phase     = n_gate_l;
        o_result.duty_out      = n_duty;
        o_result.mode_out      = MODE_W'(n_mode);
        o_result.stall_flag    = stall;
        o_result.capture_valid = cap;
        o_result.capture_value = cap ? CAP_W'(r_count) : '0;
        o_result.capture_slot  = cap ? SLOT_OUT_W'(r_slot) : '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hall_six_step_commutator.sv =====
// hall_six_step_commutator: top level; input register, config registers, output register
// around hcm_core. Uses hcm_pkg and hcm_core.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | sink      | i_in_valid/o_in_stall   | i_in_item  (t_in_item)
//  out     | source    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the output is not stalled; an accepted input
// passes the input register, then the core's next-state logic into the output register.
// Reset is synchronous on i_rst_n: mode init, gates off, duty and timer cleared,
// direction clockwise, run duty 50. A stalled output holds its result while one more
// input transaction still lands in the input register; config writes complete at once.
`default_nettype none

module hall_six_step_commutator
    import hcm_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item core_result;
    logic      out_free;
    logic      fire;
    logic      accept;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign fire        = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept || (r_in_vld && !fire);
            r_out_vld <= fire || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction_forward <= 1'b1;
            r_cfg.run_duty          <= RUN_DUTY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIRECTION: r_cfg.direction_forward <= i_cfg_data[0];
                CFG_RUN_DUTY:  r_cfg.run_duty          <= DUTY_W'(i_cfg_data);
                default:       r_cfg                   <= r_cfg;
            endcase
        end
    end

    hcm_core #(
        .RING_DEPTH  (RING_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/hcm_checker.sv =====
// hcm_checker: port-level assertions for hall_six_step_commutator, bound to the top level.
// Uses hcm_pkg.
`default_nettype none

module hcm_checker
    import hcm_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_in_item              i_in_item,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out_item             o_out_item,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // no capture means zeroed capture fields
    a_cap_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.capture_valid |->
            o_out_item.capture_value == '0 && o_out_item.capture_slot == '0)
        else $error("capture fields set without capture");

    // stop and error keep the bridge off
    a_shut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.mode_out == MODE_W'(MODE_STOP) ||
                        o_out_item.mode_out == MODE_W'(MODE_ERROR)) |->
            o_out_item.high_phase == PHASE_NONE && o_out_item.low_phase == PHASE_NONE &&
            o_out_item.duty_out == '0)
        else $error("switches on in stop or error");

    // a stall report and a capture exclude each other
    a_stall_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.stall_flag |-> !o_out_item.capture_valid)
        else $error("stall flag with hall edge");

    // nothing leaves right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind hall_six_step_commutator hcm_checker u_hcm_checker (.*);

`default_nettype wire
